// File: hdl/gsc_pkg.sv
// Shared types, codes and microprogram for the gas sensor calibration sequencer.
// No dependencies; imported by every module of the block.
package gsc_pkg;

   localparam int DIV_W  = 40;
   localparam int DVS_W  = 32;
   localparam int PC_W   = 4;
   localparam int CSR_AW = 5;
   localparam int TICK_W = 20;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic [1:0] STATUS_NC      = 2'd0;
   localparam logic [1:0] STATUS_PREHEAT = 2'd1;
   localparam logic [1:0] STATUS_CAL     = 2'd2;
   localparam logic [1:0] STATUS_READY   = 2'd3;

   localparam logic [2:0] REG_DISCONNECT = 3'd0;
   localparam logic [2:0] REG_PREHEAT    = 3'd1;
   localparam logic [2:0] REG_INTERVAL   = 3'd2;
   localparam logic [2:0] REG_COUNT      = 3'd3;
   localparam logic [2:0] REG_LOAD       = 3'd4;
   localparam logic [2:0] REG_CLEAN_AIR  = 3'd5;

   typedef enum logic [3:0] {
      STG_NC      = 4'b0001,
      STG_PREHEAT = 4'b0010,
      STG_CAL     = 4'b0100,
      STG_READY   = 4'b1000
   } stage_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_FETCH,
      UOP_TICK,
      UOP_MUL,
      UOP_DIV_RS,
      UOP_ACC,
      UOP_DIV_AVG,
      UOP_AVG,
      UOP_DIV_RO,
      UOP_RO,
      UOP_DIV_RATIO,
      UOP_RATIO,
      UOP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NO_TAKE,
      C_ROUND_OPEN,
      C_READY,
      C_DIV_BUSY,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type          op;
      cond_type         hold_cond;
      cond_type         jump_cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   localparam logic [PC_W-1:0] PC_FETCH       = 4'd0;
   localparam logic [PC_W-1:0] PC_TICK        = 4'd1;
   localparam logic [PC_W-1:0] PC_MUL         = 4'd2;
   localparam logic [PC_W-1:0] PC_RS_START    = 4'd3;
   localparam logic [PC_W-1:0] PC_RS_WAIT     = 4'd4;
   localparam logic [PC_W-1:0] PC_ACC         = 4'd5;
   localparam logic [PC_W-1:0] PC_AVG_START   = 4'd6;
   localparam logic [PC_W-1:0] PC_AVG_WAIT    = 4'd7;
   localparam logic [PC_W-1:0] PC_AVG         = 4'd8;
   localparam logic [PC_W-1:0] PC_RO_START    = 4'd9;
   localparam logic [PC_W-1:0] PC_RO_WAIT     = 4'd10;
   localparam logic [PC_W-1:0] PC_RO          = 4'd11;
   localparam logic [PC_W-1:0] PC_RATIO_START = 4'd12;
   localparam logic [PC_W-1:0] PC_RATIO_WAIT  = 4'd13;
   localparam logic [PC_W-1:0] PC_RATIO       = 4'd14;
   localparam logic [PC_W-1:0] PC_EMIT        = 4'd15;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{op: UOP_NOP, hold_cond: C_NEVER, jump_cond: C_NEVER, target: PC_FETCH};
      unique case (addr)
         PC_FETCH:       w = '{UOP_FETCH,     C_NO_REQ,   C_NEVER,      PC_FETCH};
         PC_TICK:        w = '{UOP_TICK,      C_NEVER,    C_NO_TAKE,    PC_EMIT};
         PC_MUL:         w = '{UOP_MUL,       C_NEVER,    C_NEVER,      PC_FETCH};
         PC_RS_START:    w = '{UOP_DIV_RS,    C_NEVER,    C_NEVER,      PC_FETCH};
         PC_RS_WAIT:     w = '{UOP_NOP,       C_DIV_BUSY, C_NEVER,      PC_FETCH};
         PC_ACC:         w = '{UOP_ACC,       C_NEVER,    C_ROUND_OPEN, PC_EMIT};
         PC_AVG_START:   w = '{UOP_DIV_AVG,   C_NEVER,    C_NEVER,      PC_FETCH};
         PC_AVG_WAIT:    w = '{UOP_NOP,       C_DIV_BUSY, C_NEVER,      PC_FETCH};
         PC_AVG:         w = '{UOP_AVG,       C_NEVER,    C_READY,      PC_RATIO_START};
         PC_RO_START:    w = '{UOP_DIV_RO,    C_NEVER,    C_NEVER,      PC_FETCH};
         PC_RO_WAIT:     w = '{UOP_NOP,       C_DIV_BUSY, C_NEVER,      PC_FETCH};
         PC_RO:          w = '{UOP_RO,        C_NEVER,    C_NEVER,      PC_FETCH};
         PC_RATIO_START: w = '{UOP_DIV_RATIO, C_NEVER,    C_NEVER,      PC_FETCH};
         PC_RATIO_WAIT:  w = '{UOP_NOP,       C_DIV_BUSY, C_NEVER,      PC_FETCH};
         PC_RATIO:       w = '{UOP_RATIO,     C_NEVER,    C_NEVER,      PC_FETCH};
         PC_EMIT:        w = '{UOP_EMIT,      C_OUT_BUSY, C_ALWAYS,     PC_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic [1:0] stage_status(input stage_type s);
      logic [1:0] code;
      code = STATUS_NC;
      unique case (s)
         STG_NC:      code = STATUS_NC;
         STG_PREHEAT: code = STATUS_PREHEAT;
         STG_CAL:     code = STATUS_CAL;
         STG_READY:   code = STATUS_READY;
         default:     code = STATUS_NC;
      endcase
      return code;
   endfunction

   function automatic logic [31:0] sat32(input logic [DIV_W-1:0] v);
      return (|v[DIV_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
      return (|v[DIV_W-1:16]) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// File: hdl/gsc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on gsc_pkg for the dividend and divisor widths.
module gsc_div import gsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/gas_sensor_calibration_fsm.sv
// Top level of the gas sensor preheat and calibration sequencer.
// Depends on gsc_pkg (microprogram, types) and gsc_div (shared divider).
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_adc_sample
//  rsp      out        rsp_valid/stall    status, rs, ro, ratio, ratio_valid, average_done
//  csr      in         APB psel/penable   six registers at byte address 4*index
//
// A tick without a resistance sample skips the divider, a sample tick runs one division, and the tick
// that closes an averaging round runs more of them (four divisions during calibration).
// Each division occupies the shared divider, one quotient bit per cycle.
// Reset is synchronous; the next item is taken while a result still waits in the output
// register, and the final step holds while that result is valid and rsp_stall is high.
module gas_sensor_calibration_fsm import gsc_pkg::*; #(
   parameter int ADC_BITS    = 10,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ADC_BITS-1:0] req_adc_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_rs_value,
   output logic [31:0]         rsp_ro_value,
   output logic [15:0]         rsp_ratio,
   output logic                rsp_ratio_valid,
   output logic                rsp_average_done,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int PROD_W = ADC_BITS + 8;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = 32 + $clog2(MAX_SAMPLES);
   localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

   logic [ADC_BITS-1:0] thr_ff;
   logic [TICK_W-1:0]   preheat_ff;
   logic [15:0]         interval_ff;
   logic [6:0]          count_ff;
   logic [7:0]          load_ff;
   logic [11:0]         caf_ff;
   logic                csr_write;
   logic [2:0]          csr_index;

   logic [PC_W-1:0]     pc_ff, pc_in;
   stage_type           stage_ff, stage_in;
   logic [ADC_BITS-1:0] raw_ff, raw_in;
   logic [ADC_BITS-1:0] ref_ff, ref_in;
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    samples_ff, samples_in;
   logic [31:0]         ro_ff, ro_in;
   logic [31:0]         rs_ff, rs_in;
   logic [31:0]         avg_ff, avg_in;
   logic [15:0]         ratio_ff, ratio_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                done_ff, done_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_rs_ff, rsp_rs_in;
   logic [31:0]         rsp_ro_ff, rsp_ro_in;
   logic [15:0]         rsp_ratio_ff, rsp_ratio_in;
   logic                rsp_rvalid_ff, rsp_rvalid_in;
   logic                rsp_done_ff, rsp_done_in;

   ucode_type           uw;
   logic                hold_hit;
   logic                jump_hit;
   logic                step_go;
   logic                out_busy;
   logic                take;
   logic                round_open;
   logic                disc;
   logic                unstable;
   logic [TICK_W-1:0]   elapsed_inc;
   logic [CNT_W-1:0]    n_eff;
   logic [31:0]         sample_rs;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [DVS_W-1:0]    div_divisor;
   logic                div_busy;
   logic [DIV_W-1:0]    div_quotient;

   gsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= ADC_BITS'(1003);
         preheat_ff  <= TICK_W'(20000);
         interval_ff <= 16'd50;
         count_ff    <= 7'd5;
         load_ff     <= 8'd20;
         caf_ff      <= 12'd70;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DISCONNECT: thr_ff      <= csr_pwdata[ADC_BITS-1:0];
            REG_PREHEAT:    preheat_ff  <= csr_pwdata[TICK_W-1:0];
            REG_INTERVAL:   interval_ff <= csr_pwdata[15:0];
            REG_COUNT:      count_ff    <= csr_pwdata[6:0];
            REG_LOAD:       load_ff     <= csr_pwdata[7:0];
            REG_CLEAN_AIR:  caf_ff      <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DISCONNECT: csr_prdata = 32'(thr_ff);
         REG_PREHEAT:    csr_prdata = 32'(preheat_ff);
         REG_INTERVAL:   csr_prdata = 32'(interval_ff);
         REG_COUNT:      csr_prdata = 32'(count_ff);
         REG_LOAD:       csr_prdata = 32'(load_ff);
         REG_CLEAN_AIR:  csr_prdata = 32'(caf_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // datapath conditions
   always_comb begin
      if (count_ff == 7'd0) begin
         n_eff = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_SAMPLES)) begin
         n_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = CNT_W'(count_ff);
      end
   end

   assign disc        = raw_ff >= thr_ff;
   assign unstable    = ({1'b0, raw_ff} > ({1'b0, ref_ff} + (ADC_BITS+1)'(1))) ||
                        ({1'b0, ref_ff} > ({1'b0, raw_ff} + (ADC_BITS+1)'(1)));
   assign elapsed_inc = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + TICK_W'(1);
   assign take        = !disc && (stage_ff == STG_CAL || stage_ff == STG_READY) &&
                        (elapsed_inc >= TICK_W'(interval_ff));
   assign round_open  = ({1'b0, samples_ff} + (CNT_W+1)'(1)) < {1'b0, n_eff};
   assign sample_rs   = (raw_ff == '0) ? 32'hFFFF_FFFF : sat32(div_quotient);
   assign out_busy    = rsp_valid_ff && rsp_stall;

   // sequencer
   assign uw = ucode_rom(pc_ff);

   always_comb begin
      unique case (uw.hold_cond)
         C_NEVER:      hold_hit = 1'b0;
         C_ALWAYS:     hold_hit = 1'b1;
         C_NO_REQ:     hold_hit = !req_valid;
         C_NO_TAKE:    hold_hit = !take;
         C_ROUND_OPEN: hold_hit = round_open;
         C_READY:      hold_hit = stage_ff == STG_READY;
         C_DIV_BUSY:   hold_hit = div_busy;
         C_OUT_BUSY:   hold_hit = out_busy;
         default:      hold_hit = 1'b0;
      endcase
      unique case (uw.jump_cond)
         C_NEVER:      jump_hit = 1'b0;
         C_ALWAYS:     jump_hit = 1'b1;
         C_NO_REQ:     jump_hit = !req_valid;
         C_NO_TAKE:    jump_hit = !take;
         C_ROUND_OPEN: jump_hit = round_open;
         C_READY:      jump_hit = stage_ff == STG_READY;
         C_DIV_BUSY:   jump_hit = div_busy;
         C_OUT_BUSY:   jump_hit = out_busy;
         default:      jump_hit = 1'b0;
      endcase
   end

   assign step_go   = !hold_hit;
   assign req_stall = pc_ff != PC_FETCH;

   always_comb begin
      if (!step_go) begin
         pc_in = pc_ff;
      end else if (jump_hit) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_comb begin
      stage_in      = stage_ff;
      raw_in        = raw_ff;
      ref_in        = ref_ff;
      elapsed_in    = elapsed_ff;
      sum_in        = sum_ff;
      samples_in    = samples_ff;
      ro_in         = ro_ff;
      rs_in         = rs_ff;
      avg_in        = avg_ff;
      ratio_in      = ratio_ff;
      prod_in       = prod_ff;
      done_in       = done_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      rsp_valid_in  = (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_ro_in     = rsp_ro_ff;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_done_in   = rsp_done_ff;
      if (step_go) begin
         unique case (uw.op)
            UOP_NOP: ;
            UOP_FETCH: begin
               raw_in  = req_adc_sample;
               done_in = 1'b0;
            end
            UOP_TICK: begin
               if (disc) begin
                  stage_in = STG_NC;
               end else begin
                  unique case (stage_ff)
                     STG_NC: begin
                        stage_in   = STG_PREHEAT;
                        elapsed_in = '0;
                        ref_in     = raw_ff;
                     end
                     STG_PREHEAT: begin
                        if (unstable) begin
                           elapsed_in = '0;
                           ref_in     = raw_ff;
                        end else if (elapsed_inc >= preheat_ff) begin
                           stage_in   = STG_CAL;
                           elapsed_in = '0;
                           sum_in     = '0;
                           samples_in = '0;
                        end else begin
                           elapsed_in = elapsed_inc;
                        end
                     end
                     STG_CAL, STG_READY: begin
                        elapsed_in = take ? '0 : elapsed_inc;
                     end
                     default: ;
                  endcase
               end
            end
            UOP_MUL: begin
               prod_in = PROD_W'(load_ff) * PROD_W'(FULL_SCALE - raw_ff);
            end
            UOP_DIV_RS: begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({prod_ff, 8'd0});
               div_divisor  = DVS_W'(raw_ff);
            end
            UOP_ACC: begin
               sum_in     = sum_ff + SUM_W'(sample_rs);
               samples_in = samples_ff + CNT_W'(1);
            end
            UOP_DIV_AVG: begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(sum_ff);
               div_divisor  = DVS_W'(n_eff);
            end
            UOP_AVG: begin
               done_in    = 1'b1;
               sum_in     = '0;
               samples_in = '0;
               avg_in     = sat32(div_quotient);
               if (stage_ff == STG_READY) begin
                  rs_in = sat32(div_quotient);
               end
            end
            UOP_DIV_RO: begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({avg_ff, 4'd0});
               div_divisor  = DVS_W'(caf_ff);
            end
            UOP_RO: begin
               ro_in    = (caf_ff == '0) ? 32'hFFFF_FFFF : sat32(div_quotient);
               stage_in = STG_READY;
            end
            UOP_DIV_RATIO: begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({rs_ff, 8'd0});
               div_divisor  = ro_ff;
            end
            UOP_RATIO: begin
               ratio_in = (ro_ff == '0) ? 16'hFFFF : sat16(div_quotient);
            end
            UOP_EMIT: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stage_status(stage_ff);
               rsp_rs_in     = rs_ff;
               rsp_ro_in     = ro_ff;
               rsp_ratio_in  = (stage_ff == STG_READY) ? ratio_ff : 16'd0;
               rsp_rvalid_in = stage_ff == STG_READY;
               rsp_done_in   = done_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         stage_ff     <= STG_NC;
         ref_ff       <= '0;
         elapsed_ff   <= '0;
         sum_ff       <= '0;
         samples_ff   <= '0;
         ro_ff        <= '0;
         rs_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         stage_ff     <= stage_in;
         ref_ff       <= ref_in;
         elapsed_ff   <= elapsed_in;
         sum_ff       <= sum_in;
         samples_ff   <= samples_in;
         ro_ff        <= ro_in;
         rs_ff        <= rs_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff        <= raw_in;
      avg_ff        <= avg_in;
      ratio_ff      <= ratio_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_ro_ff     <= rsp_ro_in;
      rsp_ratio_ff  <= rsp_ratio_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_rs_value     = rsp_rs_ff;
   assign rsp_ro_value     = rsp_ro_ff;
   assign rsp_ratio        = rsp_ratio_ff;
   assign rsp_ratio_valid  = rsp_rvalid_ff;
   assign rsp_average_done = rsp_done_ff;

endmodule

// File: hdl/gsc_chk.sv
// Port-level checker for the gas sensor calibration sequencer, bound to the top level.
// Depends on gsc_pkg for the status codes.
module gsc_chk import gsc_pkg::*; #(
   parameter int ADC_BITS = 10
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [ADC_BITS-1:0] req_adc_sample,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [31:0]         rsp_rs_value,
   input logic [31:0]         rsp_ro_value,
   input logic [15:0]         rsp_ratio,
   input logic                rsp_ratio_valid,
   input logic                rsp_average_done
);

   a_ratio_valid_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ratio_valid == (rsp_status == STATUS_READY)))
      else $error("ratio_valid disagrees with status");

   a_ratio_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ratio_valid) |-> (rsp_ratio == 16'd0))
      else $error("ratio non-zero while not ready");

   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_average_done) |-> (rsp_status == STATUS_READY))
      else $error("averaging round closed outside ready");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transfer taken while a tick is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rs_value) &&
                                    $stable(rsp_ro_value) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind gas_sensor_calibration_fsm gsc_chk #(.ADC_BITS(ADC_BITS)) u_gsc_chk (.*);
